[hw/rtl/pdl_pkg.sv]
// package for the password door lock controller
// shared constants, register indexes, phase and result types
// no dependencies
`timescale 1ns / 1ps

package pdl_pkg;

	localparam int PASS_LEN_DEF = 5;

	// configuration port
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MOTION  = 2'd0,
		REG_HOLD    = 2'd1,
		REG_LOCKOUT = 2'd2,
		REG_TRIALS  = 2'd3
	} reg_idx_t;

	localparam logic [7:0] MOTION_RST  = 8'd15;
	localparam logic [7:0] HOLD_RST    = 8'd3;
	localparam logic [7:0] LOCKOUT_RST = 8'd60;
	localparam logic [2:0] TRIALS_RST  = 3'd3;
	localparam logic [2:0] TRIALS_MAX  = 3'd7;

	// input kind carried on tuser
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam logic REPLY_OK  = 1'b1;
	localparam logic REPLY_BAD = 1'b0;

	localparam logic [1:0] MOTOR_OFF   = 2'd0;
	localparam logic [1:0] MOTOR_CW    = 2'd1;
	localparam logic [1:0] MOTOR_CCW   = 2'd2;

	typedef enum logic [7:0] {
		PH_SETUP1 = 8'b0000_0001,
		PH_SETUP2 = 8'b0000_0010,
		PH_MENU   = 8'b0000_0100,
		PH_ENTRY  = 8'b0000_1000,
		PH_OPEN   = 8'b0001_0000,
		PH_HOLD   = 8'b0010_0000,
		PH_CLOSE  = 8'b0100_0000,
		PH_LOCK   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t     ph;
		logic [7:0] secs;
	} timed_entry_t;

	// result beat, lowest bit first: tx_valid, tx_byte, motor, buzzer, busy_res
	typedef struct packed {
		logic [1:0] pad;
		logic       busy_res;
		logic       buzzer;
		logic [1:0] motor;
		logic       tx_byte;
		logic       tx_valid;
	} result_t;

endpackage

[hw/rtl/password_door_lock_controller.sv]
// password door lock controller top level
// path: a beat is taken into the input register, and its result is written to the output
// register; m_tready back-pressure can hold the beat in the input register in between
// throughput: one beat per cycle; the single-pass stage only stalls on m_tready
// reset (arst_n low, asynchronous): setup first entry, counters cleared, config to defaults
// depends on pdl_pkg
`timescale 1ns / 1ps

module password_door_lock_controller #(
	parameter int PASS_LEN = pdl_pkg::PASS_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [pdl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // rx_byte
	input  logic                            s_tuser,   // cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata    // tx_valid, tx_byte, motor[1:0], buzzer, busy_res, 2'b0
);
	import pdl_pkg::*;

	localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PASS_LEN - 1);

	// configuration registers
	logic [7:0] motion_q, hold_q, lockout_q;
	logic [2:0] max_trials_q;

	// input register
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;

	// controller state
	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             mismatch_q, mismatch_d;
	logic [2:0]       trials_q, trials_d;
	logic [7:0]       secs_q, secs_d;
	logic             choice_q, choice_d;
	logic [7:0]       first_q  [PASS_LEN];
	logic [7:0]       stored_q [PASS_LEN];

	logic         advance;
	logic         timed, last, ne_first, ne_stored, mism_n;
	logic         first_we, copy_pw;
	logic         txv, txb;
	logic [2:0]   trial_inc;
	timed_entry_t te;
	result_t      res_d;
	logic         m_tvalid_q;
	result_t      m_data_q;

	// chained entry into a timed phase; zero length phases fall through
	function automatic timed_entry_t enter_ph(phase_t p, logic [7:0] mot, logic [7:0] hld,
			logic [7:0] lck);
		timed_entry_t r;
		r.ph   = PH_MENU;
		r.secs = 8'd0;
		case (p)
			PH_OPEN: begin
				if (mot != 8'd0) begin
					r.ph = PH_OPEN; r.secs = mot;
				end else if (hld != 8'd0) begin
					r.ph = PH_HOLD; r.secs = hld;
				end
			end
			PH_HOLD: begin
				if (hld != 8'd0) begin
					r.ph = PH_HOLD; r.secs = hld;
				end else if (mot != 8'd0) begin
					r.ph = PH_CLOSE; r.secs = mot;
				end
			end
			PH_CLOSE: begin
				if (mot != 8'd0) begin
					r.ph = PH_CLOSE; r.secs = mot;
				end
			end
			PH_LOCK: begin
				if (lck != 8'd0) begin
					r.ph = PH_LOCK; r.secs = lck;
				end
			end
			default: begin
				r.ph = PH_MENU;
			end
		endcase
		return r;
	endfunction

	function automatic phase_t next_ph(phase_t p);
		phase_t r;
		case (p)
			PH_OPEN: r = PH_HOLD;
			PH_HOLD: r = PH_CLOSE;
			default: r = PH_MENU;
		endcase
		return r;
	endfunction

	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q     <= MOTION_RST;
			hold_q       <= HOLD_RST;
			lockout_q    <= LOCKOUT_RST;
			max_trials_q <= TRIALS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MOTION:  motion_q     <= cfg_wdata;
				REG_HOLD:    hold_q       <= cfg_wdata;
				REG_LOCKOUT: lockout_q    <= cfg_wdata;
				REG_TRIALS:  max_trials_q <= cfg_wdata[2:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		mismatch_d = mismatch_q;
		trials_d   = trials_q;
		secs_d     = secs_q;
		choice_d   = choice_q;
		first_we   = 1'b0;
		copy_pw    = 1'b0;
		txv        = 1'b0;
		txb        = REPLY_BAD;
		te         = enter_ph(PH_MENU, motion_q, hold_q, lockout_q);
		timed      = phase_q inside {PH_OPEN, PH_HOLD, PH_CLOSE, PH_LOCK};
		last       = (idx_q == IDX_LAST);
		ne_first   = (first_q[idx_q] != byte_s1);
		ne_stored  = (stored_q[idx_q] != byte_s1);
		trial_inc  = (trials_q != TRIALS_MAX) ? trials_q + 3'd1 : trials_q;
		mism_n     = mismatch_q;

		if (cmd_s1 == CMD_TICK) begin
			if (timed && secs_q != 8'd0) begin
				secs_d = secs_q - 8'd1;
				if (secs_q == 8'd1) begin
					te      = enter_ph(next_ph(phase_q), motion_q, hold_q, lockout_q);
					phase_d = te.ph;
					secs_d  = te.secs;
				end
			end
		end else if (!timed) begin
			case (phase_q)
				PH_SETUP1: begin
					first_we = 1'b1;
					if (idx_q == '0) mismatch_d = 1'b0;
					if (last) begin
						idx_d      = '0;
						mismatch_d = 1'b0;
						phase_d    = PH_SETUP2;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				PH_SETUP2: begin
					mism_n     = mismatch_q | ne_first;
					mismatch_d = mism_n;
					if (last) begin
						idx_d      = '0;
						txv        = 1'b1;
						mismatch_d = 1'b0;
						if (!mism_n) begin
							copy_pw = 1'b1;
							txb     = REPLY_OK;
							phase_d = PH_MENU;
						end else begin
							phase_d = PH_SETUP1;
						end
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				PH_MENU: begin
					idx_d      = '0;
					mismatch_d = 1'b0;
					if (byte_s1 == CHAR_PLUS) begin
						choice_d = 1'b0;
						phase_d  = PH_ENTRY;
					end else if (byte_s1 == CHAR_MINUS) begin
						choice_d = 1'b1;
						phase_d  = PH_ENTRY;
					end else begin
						phase_d = PH_SETUP1;
					end
				end
				PH_ENTRY: begin
					mism_n     = mismatch_q | ne_stored;
					mismatch_d = mism_n;
					if (last) begin
						idx_d      = '0;
						txv        = 1'b1;
						mismatch_d = 1'b0;
						if (!mism_n) begin
							txb      = REPLY_OK;
							trials_d = 3'd0;
							if (!choice_q) begin
								te      = enter_ph(PH_OPEN, motion_q, hold_q, lockout_q);
								phase_d = te.ph;
								secs_d  = te.secs;
							end else begin
								phase_d = PH_SETUP1;
							end
						end else begin
							trials_d = trial_inc;
							// limit reached: clear the count and lock out
							if (trial_inc >= max_trials_q) begin
								trials_d = 3'd0;
								te       = enter_ph(PH_LOCK, motion_q, hold_q, lockout_q);
								phase_d  = te.ph;
								secs_d   = te.secs;
							end
						end
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		res_d          = '0;
		res_d.tx_valid = txv;
		res_d.tx_byte  = txb;
		res_d.motor    = (phase_d == PH_OPEN)  ? MOTOR_CW :
		                 (phase_d == PH_CLOSE) ? MOTOR_CCW : MOTOR_OFF;
		res_d.buzzer   = (phase_d == PH_LOCK);
		res_d.busy_res = phase_d inside {PH_OPEN, PH_HOLD, PH_CLOSE, PH_LOCK};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SETUP1;
			idx_q      <= '0;
			mismatch_q <= 1'b0;
			trials_q   <= 3'd0;
			secs_q     <= 8'd0;
			choice_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			phase_q    <= phase_d;
			idx_q      <= idx_d;
			mismatch_q <= mismatch_d;
			trials_q   <= trials_d;
			secs_q     <= secs_d;
			choice_q   <= choice_d;
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			m_data_q <= res_d;
			if (first_we) first_q[idx_q] <= byte_s1;
			if (copy_pw) stored_q <= first_q;
		end
	end

endmodule

[hw/rtl/pdl_checker.sv]
// port-level checks for the password door lock controller, bound to the top level
// depends on the port layout of password_door_lock_controller
`timescale 1ns / 1ps

module pdl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [1:0] cfg_addr,
	input logic [7:0] cfg_wdata,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// motor code three never driven
	a_motor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:2] != 2'd3)
		else $error("bad motor code");

	// buzzer or a running motor both mean busy, and never together
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[4] || m_tdata[3:2] != 2'd0) |-> m_tdata[5])
		else $error("buzzer or motor without busy");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[3:2] == 2'd0)
		else $error("motor runs during lockout");

	// a confirm reply only comes with a reply beat
	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("reply byte without reply flag");

endmodule

bind password_door_lock_controller pdl_checker u_pdl_checker (.*);

[tb/door_lock_checker.sv]
// result checker for the password door lock controller
// predicts each result beat from the accepted input beats and config writes and compares them
// depends on pdl_pkg
`timescale 1ns / 1ps

module door_lock_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdl_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [pdl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,
	output int                             fail_count,
	output int                             awaited
);
	import pdl_pkg::*;

	localparam int PW_LEN = PASS_LEN_DEF;

	logic [7:0] motion_s, hold_s, lockout_s;
	logic [2:0] trial_limit;

	phase_t      ph;
	int unsigned pos;
	logic [7:0]  entry1 [PW_LEN];
	logic [7:0]  secret [PW_LEN];
	logic        differs;
	logic [2:0]  trials;
	logic [7:0]  secs_left;
	logic        wants_setup;

	result_t awaited_q [$];
	result_t want, got;

	function automatic logic is_busy(phase_t p);
		return p == PH_OPEN || p == PH_HOLD || p == PH_CLOSE || p == PH_LOCK;
	endfunction

	function automatic phase_t phase_after(phase_t p);
		case (p)
			PH_OPEN: return PH_HOLD;
			PH_HOLD: return PH_CLOSE;
			default: return PH_MENU;
		endcase
	endfunction

	// timed phases with a zero duration fall straight through to the next one
	function automatic void start_phase(phase_t p);
		phase_t cur;
		logic   done;
		cur = p;
		done = 1'b0;
		while (!done) begin
			ph = cur;
			case (cur)
				PH_OPEN, PH_CLOSE: secs_left = motion_s;
				PH_HOLD:           secs_left = hold_s;
				PH_LOCK:           secs_left = lockout_s;
				default:           secs_left = 8'd0;
			endcase
			if (!is_busy(cur) || secs_left != 8'd0) done = 1'b1;
			else cur = phase_after(cur);
		end
	endfunction

	function automatic result_t lock_step(logic kind, logic [7:0] b);
		result_t     r;
		int unsigned i;
		logic        at_end;
		r = '0;
		if (kind == CMD_TICK) begin
			if (is_busy(ph) && secs_left != 8'd0) begin
				secs_left = secs_left - 8'd1;
				if (secs_left == 8'd0) start_phase(phase_after(ph));
			end
		end else if (!is_busy(ph)) begin
			i = pos % PW_LEN;
			at_end = (i + 1 >= PW_LEN);
			case (ph)
				PH_SETUP1: begin
					entry1[i] = b;
					if (i == 0) differs = 1'b0;
					if (at_end) begin
						pos = 0;
						differs = 1'b0;
						ph = PH_SETUP2;
					end else pos = i + 1;
				end
				PH_SETUP2: begin
					if (entry1[i] != b) differs = 1'b1;
					if (at_end) begin
						pos = 0;
						r.tx_valid = 1'b1;
						if (!differs) begin
							secret = entry1;
							r.tx_byte = REPLY_OK;
							ph = PH_MENU;
						end else begin
							r.tx_byte = REPLY_BAD;
							ph = PH_SETUP1;
						end
						differs = 1'b0;
					end else pos = i + 1;
				end
				PH_MENU: begin
					pos = 0;
					differs = 1'b0;
					if (b == CHAR_PLUS) begin
						wants_setup = 1'b0;
						ph = PH_ENTRY;
					end else if (b == CHAR_MINUS) begin
						wants_setup = 1'b1;
						ph = PH_ENTRY;
					end else ph = PH_SETUP1;
				end
				default: begin
					if (secret[i] != b) differs = 1'b1;
					if (at_end) begin
						pos = 0;
						r.tx_valid = 1'b1;
						if (!differs) begin
							r.tx_byte = REPLY_OK;
							trials = 3'd0;
							if (!wants_setup) start_phase(PH_OPEN);
							else ph = PH_SETUP1;
						end else begin
							r.tx_byte = REPLY_BAD;
							if (trials < TRIALS_MAX) trials = trials + 3'd1;
							// a zero limit locks out on the first wrong entry
							if (trials >= trial_limit) begin
								trials = 3'd0;
								start_phase(PH_LOCK);
							end
						end
						differs = 1'b0;
					end else pos = i + 1;
				end
			endcase
		end
		r.motor = (ph == PH_OPEN) ? MOTOR_CW : ((ph == PH_CLOSE) ? MOTOR_CCW : MOTOR_OFF);
		r.buzzer = (ph == PH_LOCK);
		r.busy_res = is_busy(ph);
		return r;
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_s = MOTION_RST;
			hold_s = HOLD_RST;
			lockout_s = LOCKOUT_RST;
			trial_limit = TRIALS_RST;
			ph = PH_SETUP1;
			pos = 0;
			for (int k = 0; k < PW_LEN; k++) begin
				entry1[k] = 8'd0;
				secret[k] = 8'd0;
			end
			differs = 1'b0;
			trials = 3'd0;
			secs_left = 8'd0;
			wants_setup = 1'b0;
			awaited_q.delete();
			fail_count = 0;
			awaited = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_MOTION:  motion_s = cfg_wdata;
					REG_HOLD:    hold_s = cfg_wdata;
					REG_LOCKOUT: lockout_s = cfg_wdata;
					REG_TRIALS:  trial_limit = cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) awaited_q.push_back(lock_step(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (awaited_q.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, expected none, actual %h",
						$time, got);
					fail_count++;
				end else begin
					want = awaited_q.pop_front();
					check_field("tx_valid", want.tx_valid, got.tx_valid);
					check_field("tx_byte", want.tx_byte, got.tx_byte);
					check_field("motor", want.motor, got.motor);
					check_field("buzzer", want.buzzer, got.buzzer);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("pad", want.pad, got.pad);
				end
			end
			awaited = awaited_q.size();
		end
	end

endmodule

[tb/tb_password_door_lock_controller.sv]
// testbench top for the password door lock controller
// drives password, menu and tick beats under several register settings, random backpressure
// depends on pdl_pkg, password_door_lock_controller and door_lock_checker
`timescale 1ns / 1ps

module tb_password_door_lock_controller;
	import pdl_pkg::*;

	localparam int PW_LEN = PASS_LEN_DEF;
	localparam int STALL_LIMIT = 2000;

	typedef logic [PW_LEN-1:0][7:0] code_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'd0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;
	int                    fail_count;
	int                    awaited;

	int   stall_cycles = 0;
	int   useful = 0;
	logic steady = 1'b0;

	// stimulus-side view of the lock, just enough to keep sequences aligned
	logic [7:0] cfg_motion = MOTION_RST;
	logic [7:0] cfg_hold = HOLD_RST;
	logic [7:0] cfg_lockout = LOCKOUT_RST;
	logic [2:0] cfg_trials = TRIALS_RST;
	logic       in_menu = 1'b0;
	logic [2:0] misses = 3'd0;
	code_t      known_pw = '0;

	password_door_lock_controller dut (.*);
	door_lock_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 32);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else stall_cycles <= stall_cycles + 1;
	end

	task automatic send(input logic kind, input logic [7:0] data, input bit counts);
		while (!steady && $urandom_range(0, 99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (counts) useful++;
	endtask

	task automatic enter_code(input code_t c);
		for (int k = 0; k < PW_LEN; k++) send(CMD_BYTE, c[k], 1'b1);
	endtask

	function automatic code_t fresh_code();
		code_t c;
		for (int k = 0; k < PW_LEN; k++) begin
			case ($urandom_range(0, 9))
				0: c[k] = 8'h00;
				1: c[k] = 8'hFF;
				2: c[k] = CHAR_PLUS;
				3: c[k] = CHAR_MINUS;
				default: c[k] = 8'($urandom);
			endcase
		end
		return c;
	endfunction

	// always differs from c somewhere
	function automatic code_t garble(code_t c);
		code_t g;
		int    k;
		g = ($urandom_range(0, 1) == 0) ? fresh_code() : c;
		k = $urandom_range(0, PW_LEN - 1);
		g[k][$urandom_range(0, 7)] ^= 1'b1;
		if (g == c) g[0][0] ^= 1'b1;
		return g;
	endfunction

	task automatic do_setup(input code_t c, input bit agree);
		enter_code(c);
		enter_code(agree ? c : garble(c));
		if (agree) begin
			in_menu = 1'b1;
			known_pw = c;
		end
	endtask

	// n ticks of a timed phase; bytes slipped in before a tick land while busy
	task automatic run_clock(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < 10) send(CMD_BYTE, 8'($urandom), 1'b0);
			send(CMD_TICK, 8'($urandom), 1'b1);
		end
		if ($urandom_range(0, 99) < 20) send(CMD_TICK, 8'($urandom), 1'b0);
	endtask

	// a wrong entry leaves the lock waiting for another one until the limit locks it out
	task automatic do_menu(input logic [7:0] choice, input bit right);
		code_t c;
		bit    ok;
		bit    waiting;
		send(CMD_BYTE, choice, 1'b1);
		if (choice != CHAR_PLUS && choice != CHAR_MINUS) begin
			in_menu = 1'b0;
			return;
		end
		ok = right;
		waiting = 1'b1;
		while (waiting) begin
			c = ok ? known_pw : garble(known_pw);
			enter_code(c);
			if (ok) begin
				waiting = 1'b0;
				misses = 3'd0;
				if (choice == CHAR_PLUS) run_clock(2 * int'(cfg_motion) + int'(cfg_hold));
				else in_menu = 1'b0;
			end else begin
				if (misses < TRIALS_MAX) misses = misses + 3'd1;
				if (misses >= cfg_trials) begin
					waiting = 1'b0;
					misses = 3'd0;
					run_clock(int'(cfg_lockout));
				end else ok = ($urandom_range(0, 99) < 50);
			end
		end
	endtask

	task automatic random_traffic(input int goal);
		int         r;
		logic [7:0] b;
		while (useful < goal) begin
			if (!in_menu) do_setup(fresh_code(), $urandom_range(0, 99) < 80);
			else begin
				r = $urandom_range(0, 99);
				if (r < 6) send(CMD_TICK, 8'($urandom), 1'b0);
				else if (r < 16) begin
					b = 8'($urandom);
					if (b == CHAR_PLUS || b == CHAR_MINUS) b = 8'h00;
					do_menu(b, 1'b0);
				end else do_menu((r < 66) ? CHAR_PLUS : CHAR_MINUS, $urandom_range(0, 99) < 65);
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (awaited != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
	endtask

	// upper bits of the trials write are junk the block must drop
	task automatic load_config(input logic [7:0] m, input logic [7:0] h, input logic [7:0] l,
			input logic [2:0] t, input logic [4:0] junk);
		write_reg(REG_MOTION, m);
		write_reg(REG_HOLD, h);
		write_reg(REG_LOCKOUT, l);
		write_reg(REG_TRIALS, {junk, t});
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_motion = m;
		cfg_hold = h;
		cfg_lockout = l;
		cfg_trials = t;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send(CMD_TICK, 8'hFF, 1'b0);
		do_setup({8'h80, CHAR_MINUS, CHAR_PLUS, 8'hFF, 8'h00}, 1'b0);
		do_setup({8'h80, CHAR_MINUS, CHAR_PLUS, 8'hFF, 8'h00}, 1'b1);
		do_menu(CHAR_PLUS, 1'b0);
		random_traffic(250);

		settle();
		load_config(8'd1, 8'd0, 8'd1, 3'd1, 5'd0);
		steady = 1'b1;
		random_traffic(600);
		steady = 1'b0;

		// zero durations skip their phases, zero trial limit locks out at once
		settle();
		load_config(8'd0, 8'd0, 8'd0, 3'd0, 5'h1F);
		random_traffic(900);

		settle();
		load_config(8'd255, 8'd255, 8'd255, 3'd7, 5'd0);
		random_traffic(1050);

		settle();
		load_config(8'($urandom_range(1, 4)), 8'($urandom_range(0, 3)), 8'($urandom_range(1, 6)),
			3'($urandom_range(1, 7)), 5'($urandom));
		random_traffic(1450);

		settle();
		load_config(8'($urandom_range(1, 20)), 8'($urandom_range(0, 10)),
			8'($urandom_range(1, 20)), 3'($urandom_range(1, 4)), 5'($urandom));
		random_traffic(1850);

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
